@@ hw/rtl/wildcard_glob_matcher_defines.svh @@
// ----------------------------------------------------------------------------
// Wildcard glob matcher assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define WGM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wildcard_glob_matcher: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define WGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wildcard_glob_matcher: next-cycle check failed");

`endif

@@ hw/rtl/wgm_pkg.sv @@
// ----------------------------------------------------------------------------
// wgm_pkg
// Types and constants shared by the wildcard glob matcher modules.
// ----------------------------------------------------------------------------
package wgm_pkg;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_NAME   = 2'd2,
        REQ_END    = 2'd3
    } t_req_type;

    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_ANY  = 8'h3F;

    // Command queue depth, power of two
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        t_req_type   req_type;
        logic [7:0]  char_value;
    } t_req;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_rsp;

    // Classified item as it travels through the queue
    typedef struct packed {
        t_req_type   op;
        logic [7:0]  data;
        logic        is_star;
        logic        is_any;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

endpackage

@@ hw/rtl/wgm_front.sv @@
// ----------------------------------------------------------------------------
// wgm_front
// Input side: takes items and classifies the byte as star / any / literal.
// ----------------------------------------------------------------------------
module wgm_front (
    input  logic             i_valid,
    output logic             o_ready,
    input  wgm_pkg::t_req    i_req,
    input  wgm_pkg::t_q_stat i_stat,
    output logic             o_push,
    output wgm_pkg::t_cmd    o_cmd
);

    assign o_ready = !i_stat.full;
    assign o_push  = i_valid && !i_stat.full;

    always_comb begin
        o_cmd.op      = i_req.req_type;
        o_cmd.data    = i_req.char_value;
        o_cmd.is_star = (i_req.char_value == wgm_pkg::CHAR_STAR);
        o_cmd.is_any  = (i_req.char_value == wgm_pkg::CHAR_ANY);
    end

endmodule

@@ hw/rtl/wgm_queue.sv @@
// ----------------------------------------------------------------------------
// wgm_queue
// Small FIFO between front and back; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module wgm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wgm_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output wgm_pkg::t_q_stat o_stat,
    output wgm_pkg::t_cmd    o_head
);

    localparam int DEPTH = wgm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wgm_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic push_ok;
    logic pop_ok;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign push_ok = i_push && !o_stat.full;
    assign pop_ok  = i_pop && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/wgm_back.sv @@
// ----------------------------------------------------------------------------
// wgm_back
// Execution side: pattern cells, active position vector, result register.
// ----------------------------------------------------------------------------
module wgm_back #(
    parameter int PATTERN_MAX = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wgm_pkg::t_q_stat i_stat,
    input  wgm_pkg::t_cmd    i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output wgm_pkg::t_rsp    o_rsp
);

    localparam int N1    = PATTERN_MAX + 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Pattern cells, written once each while the pattern is loaded
    logic [7:0]             r_chr [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_star;
    logic [PATTERN_MAX-1:0] r_any;

    logic [LEN_W-1:0]       r_len;
    logic                   r_ovf;
    logic [N1-1:0]          r_act;
    logic                   r_out_valid;
    wgm_pkg::t_rsp          r_rsp;

    logic [PATTERN_MAX-1:0] in_len;
    logic [PATTERN_MAX-1:0] adv;
    logic [N1-1:0]          star_v;
    logic [N1-1:0]          gen_v;
    logic [N1:0]            sum;
    logic [N1:0]            carry;
    logic [N1-1:0]          closed;
    logic [N1-1:0]          n_act_step;
    logic                   end_hit;
    logic                   wr_en;
    logic                   is_end;

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            in_len[i] = (r_len > LEN_W'(i));
            star_v[i] = r_star[i] && in_len[i];
        end
        star_v[PATTERN_MAX] = 1'b0;

        // Star closure as a carry chain: an active star generates, a star propagates
        gen_v  = r_act & star_v;
        sum    = {1'b0, star_v} + {1'b0, gen_v};
        carry  = sum ^ {1'b0, star_v} ^ {1'b0, gen_v};
        closed = r_act | carry[N1-1:0];

        for (int i = 0; i < PATTERN_MAX; i++) begin
            adv[i] = closed[i] && in_len[i] && !r_star[i]
                     && (r_any[i] || (r_chr[i] == i_head.data));
        end
        n_act_step = (closed & star_v) | {adv, 1'b0};

        end_hit = (r_len == '0) || closed[r_len];
    end

    assign is_end  = (i_head.op == wgm_pkg::REQ_END);
    assign o_pop   = i_stat.valid && (!is_end || !r_out_valid || i_ready);
    assign wr_en   = o_pop && (i_head.op == wgm_pkg::REQ_APPEND)
                     && (r_len < LEN_W'(PATTERN_MAX));
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_act       <= N1'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && is_end) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                case (i_head.op)
                    wgm_pkg::REQ_CLEAR: begin
                        r_len <= '0;
                        r_ovf <= 1'b0;
                        r_act <= N1'(1);
                    end
                    wgm_pkg::REQ_APPEND: begin
                        if (r_len < LEN_W'(PATTERN_MAX)) begin
                            r_len <= r_len + LEN_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    wgm_pkg::REQ_NAME: begin
                        r_act <= n_act_step;
                    end
                    wgm_pkg::REQ_END: begin
                        r_act <= N1'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (wr_en && (r_len == LEN_W'(i))) begin
                r_chr[i]  <= i_head.data;
                r_star[i] <= i_head.is_star;
                r_any[i]  <= i_head.is_any;
            end
        end
        if (o_pop && is_end) begin
            r_rsp.matched          <= end_hit;
            r_rsp.pattern_overflow <= r_ovf;
        end
    end

endmodule

@@ hw/rtl/wildcard_glob_matcher.sv @@
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Glob matcher with '*' and '?' over a streamed name.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_data) carries requests: clear pattern,
// append pattern byte, name byte, end of name. Output channel
// (o_valid/i_ready, o_data) carries one result per end of name: matched
// and pattern_overflow.
// One item is taken per cycle while o_ready is high. The front classifies
// each byte and pushes it into a 4-entry queue; the back pops one entry per
// cycle unless halted at an end-of-name item, and updates the active position
// vector in a single pass (star closure as one carry chain, then a compare
// in every pattern cell). o_valid rises at the clock edge after the one that
// accepts the end-of-name item, when the queue is empty and the output
// register is free. Reset clears the pattern length, the overflow flag and
// the vector (position zero only); pattern bytes themselves are not cleared.
// When the receiver stalls, the result register holds its value, the back
// halts at the next end-of-name item, the queue fills and o_ready drops
// once it is full. Bytes past PATTERN_MAX are dropped and flagged.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wgm_pkg::t_req i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output wgm_pkg::t_rsp o_data
);

    wgm_pkg::t_q_stat q_stat;
    wgm_pkg::t_cmd    push_cmd;
    wgm_pkg::t_cmd    head_cmd;
    logic             push;
    logic             pop;

    wgm_front u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_data),
        .i_stat  (q_stat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    wgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_cmd)
    );

    wgm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (q_stat),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_data)
    );

endmodule

@@ hw/rtl/wgm_checker.sv @@
// ----------------------------------------------------------------------------
// wgm_checker
// Port-level checks on the glob matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "wildcard_glob_matcher_defines.svh"

module wgm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input wgm_pkg::t_rsp o_data
);

    // Held result must not change until taken
    `WGM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))

    // Queue is empty right after reset
    `WGM_ASSERT_IMPLY(a_ready_after_rst, i_clk, i_rst_n, $past(!i_rst_n), o_ready)

    // Backpressure only after items were taken
    `WGM_ASSERT_IMPLY(a_busy_has_cause, i_clk, i_rst_n, !o_ready, $past(i_valid && o_ready) || $past(!o_ready))

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: wildcard glob matcher testbench
// A short directed table and a full-store overflow check, then random
// sessions of pattern load and name streaming, with random gaps on the
// request side and random stalls on the result side. Each result is checked
// against a local bit-accurate model or a hand-written expectation.
module tb_top;

    localparam int PAT_CAP    = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 1200;
    localparam int N_PLAN     = 21;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    wgm_pkg::t_req i_data  = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    wgm_pkg::t_rsp o_data;

    wildcard_glob_matcher #(.PATTERN_MAX(PAT_CAP)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local model of the matcher
    // ------------------------------------------------------------------
    logic [7:0]       pat_mem [PAT_CAP];
    int               pat_len  = 0;
    logic [PAT_CAP:0] live     = (PAT_CAP+1)'(1);
    logic             ovf_seen = 1'b0;
    wgm_pkg::t_rsp    verdict_q [$];

    int err_cnt   = 0;
    int n_items   = 0;
    int n_results = 0;
    int n_hits    = 0;
    int n_ovf     = 0;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // a star at a live position also makes the next one live; cascades upward
    function automatic void spread_stars();
        for (int i = 0; i < pat_len; i++) begin
            if (live[i] && pat_mem[i] == wgm_pkg::CHAR_STAR) live[i+1] = 1'b1;
        end
    endfunction

    function automatic bit glob_advance(input wgm_pkg::t_req req,
                                        output wgm_pkg::t_rsp rsp);
        logic [PAT_CAP:0] nxt;
        bit               emits;
        emits = 1'b0;
        rsp   = '0;
        case (req.req_type)
            wgm_pkg::REQ_CLEAR: begin
                pat_len  = 0;
                ovf_seen = 1'b0;
                live     = (PAT_CAP+1)'(1);
            end
            wgm_pkg::REQ_APPEND: begin
                if (pat_len < PAT_CAP) begin
                    pat_mem[pat_len] = req.char_value;
                    pat_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            wgm_pkg::REQ_NAME: begin
                spread_stars();
                nxt = '0;
                for (int i = 0; i < pat_len; i++) begin
                    if (live[i]) begin
                        if (pat_mem[i] == wgm_pkg::CHAR_STAR) nxt[i] = 1'b1;
                        else if (pat_mem[i] == wgm_pkg::CHAR_ANY
                                 || pat_mem[i] == req.char_value)
                            nxt[i+1] = 1'b1;
                    end
                end
                live = nxt;
            end
            default: begin
                if (pat_len == 0) begin
                    rsp.matched = 1'b1;
                end else begin
                    spread_stars();
                    rsp.matched = live[pat_len];
                end
                rsp.pattern_overflow = ovf_seen;
                live  = (PAT_CAP+1)'(1);
                emits = 1'b1;
            end
        endcase
        return emits;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] name_byte();
        if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 2))
                0:       return 8'h61;
                1:       return 8'h62;
                default: return 8'h63;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pat_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) return wgm_pkg::CHAR_STAR;
        if (r < 40) return wgm_pkg::CHAR_ANY;
        if (r < 85) return (r[0] ? 8'h61 : 8'h62);
        return 8'($urandom_range(0, 255));
    endfunction

    // typed_hit selects a hand-written expectation over the model's
    task automatic send_item(input wgm_pkg::t_req_type op, input logic [7:0] ch,
                             input bit typed_hit, input wgm_pkg::t_rsp typed_rsp);
        int unsigned   gap;
        wgm_pkg::t_req req;
        wgm_pkg::t_rsp rsp;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.req_type   = op;
        req.char_value = ch;
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_items++;
        if (glob_advance(req, rsp)) verdict_q.push_back(typed_hit ? typed_rsp : rsp);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // one session: clear, load a pattern, then stream a few names against it, or else send a short run of random items
    task automatic run_session();
        logic [7:0]  pat [$];
        logic [7:0]  nm [$];
        int unsigned r;
        int unsigned plen;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 6))
                send_item(wgm_pkg::t_req_type'(2'($urandom_range(0, 3))),
                          8'($urandom_range(0, 255)), 1'b0, '0);
            return;
        end
        tx_calm = ($urandom_range(0, 99) < 30);
        rx_calm = ($urandom_range(0, 99) < 25);
        send_item(wgm_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
        r = $urandom_range(0, 99);
        if (r < 8)       plen = 0;
        else if (r < 60) plen = $urandom_range(1, 6);
        else if (r < 82) plen = $urandom_range(7, 20);
        else             plen = $urandom_range(25, 40);
        repeat (plen) begin
            pat.push_back(pat_byte());
            send_item(wgm_pkg::REQ_APPEND, pat[$], 1'b0, '0);
        end
        repeat ($urandom_range(1, 4)) begin
            nm.delete();
            if ($urandom_range(0, 99) < 70) begin
                // name built to fit the stored part of the pattern
                foreach (pat[k]) begin
                    if (k < PAT_CAP) begin
                        if (pat[k] == wgm_pkg::CHAR_STAR)
                            repeat ($urandom_range(0, 3)) nm.push_back(name_byte());
                        else if (pat[k] == wgm_pkg::CHAR_ANY)
                            nm.push_back(8'($urandom_range(0, 255)));
                        else
                            nm.push_back(pat[k]);
                    end
                end
                if ($urandom_range(0, 99) < 25) begin
                    if (nm.size() == 0) nm.push_back(name_byte());
                    else nm[$urandom_range(0, nm.size() - 1)] = name_byte();
                end
            end else begin
                repeat ($urandom_range(0, 6)) nm.push_back(name_byte());
            end
            foreach (nm[k]) begin
                if ($urandom_range(0, 99) < 4)
                    send_item(wgm_pkg::REQ_APPEND, pat_byte(), 1'b0, '0);
                send_item(wgm_pkg::REQ_NAME, nm[k], 1'b0, '0);
            end
            send_item(wgm_pkg::REQ_END, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
        if ($urandom_range(0, 99) < 7) drain_results();
    endtask

    // ------------------------------------------------------------------
    // Directed table; want = {matched, pattern_overflow}
    // ------------------------------------------------------------------
    typedef struct {
        wgm_pkg::t_req_type op;
        logic [7:0]         ch;
        bit                 typed_hit;
        wgm_pkg::t_rsp      want;
    } t_row;

    t_row plan [N_PLAN] = '{
        '{wgm_pkg::REQ_END,    8'hFF, 1'b1, 2'b10},  // empty pattern right after reset
        '{wgm_pkg::REQ_APPEND, 8'h61, 1'b0, 2'b00},
        '{wgm_pkg::REQ_NAME,   8'h61, 1'b0, 2'b00},
        '{wgm_pkg::REQ_END,    8'h00, 1'b0, 2'b00},
        '{wgm_pkg::REQ_CLEAR,  8'h00, 1'b0, 2'b00},
        '{wgm_pkg::REQ_APPEND, 8'h2A, 1'b0, 2'b00},
        '{wgm_pkg::REQ_END,    8'h2A, 1'b1, 2'b10},  // empty name against a lone star
        '{wgm_pkg::REQ_APPEND, 8'h3F, 1'b0, 2'b00},
        '{wgm_pkg::REQ_NAME,   8'h00, 1'b0, 2'b00},
        '{wgm_pkg::REQ_NAME,   8'hFF, 1'b0, 2'b00},
        '{wgm_pkg::REQ_END,    8'h55, 1'b0, 2'b00},
        '{wgm_pkg::REQ_CLEAR,  8'hFF, 1'b0, 2'b00},
        '{wgm_pkg::REQ_APPEND, 8'h00, 1'b0, 2'b00},  // zero byte as a literal
        '{wgm_pkg::REQ_NAME,   8'h00, 1'b0, 2'b00},
        '{wgm_pkg::REQ_APPEND, 8'hFF, 1'b0, 2'b00},  // pattern grows mid-name
        '{wgm_pkg::REQ_NAME,   8'hFF, 1'b0, 2'b00},
        '{wgm_pkg::REQ_END,    8'hAA, 1'b0, 2'b00},
        '{wgm_pkg::REQ_NAME,   8'h01, 1'b0, 2'b00},
        '{wgm_pkg::REQ_END,    8'h00, 1'b0, 2'b00},
        '{wgm_pkg::REQ_CLEAR,  8'h5A, 1'b0, 2'b00},
        '{wgm_pkg::REQ_END,    8'hA5, 1'b1, 2'b10}
    };

    initial begin
        int unsigned spin;
        foreach (pat_mem[k]) pat_mem[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_calm = 1'b1;
        for (int k = 0; k < N_PLAN; k++)
            send_item(plan[k].op, plan[k].ch, plan[k].typed_hit, plan[k].want);
        // full store: 32 stars kept, the 33rd dropped and flagged
        tx_calm = 1'b0;
        send_item(wgm_pkg::REQ_CLEAR, 8'h00, 1'b0, '0);
        repeat (PAT_CAP + 1) send_item(wgm_pkg::REQ_APPEND, wgm_pkg::CHAR_STAR, 1'b0, '0);
        send_item(wgm_pkg::REQ_END, 8'h00, 1'b1, 2'b11);
        drain_results();
        while (n_items < N_PLAN + PAT_CAP + 3 + RAND_ITEMS) run_session();
        i_valid <= 1'b0;
        rx_calm = 1'b0;
        spin = 0;
        while (verdict_q.size() != 0 && spin < 20000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (8) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, verdict_q.size());
            err_cnt++;
        end
        $display("covered %0d request items and %0d finished names", n_items, n_results);
        $display("  %0d names matched, %0d reported a dropped pattern byte", n_hits, n_ovf);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls and checking
    // ------------------------------------------------------------------
    int unsigned rdy_hold = 0;

    always @(posedge i_clk) begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (rx_calm) begin
            i_ready <= 1'b1;
        end else if (r < 65) begin
            i_ready  <= 1'b1;
            rdy_hold <= $urandom_range(0, 7);
        end else if (r < 95) begin
            i_ready  <= 1'b0;
            rdy_hold <= $urandom_range(0, 2);
        end else begin
            i_ready  <= 1'b0;
            rdy_hold <= $urandom_range(10, 40);
        end
    end

    always @(posedge i_clk) begin
        wgm_pkg::t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (o_data.matched) n_hits++;
            if (o_data.pattern_overflow) n_ovf++;
            if (verdict_q.size() == 0) begin
                $display("%0t: result with none pending, got matched %0b overflow %0b",
                         $time, o_data.matched, o_data.pattern_overflow);
                err_cnt++;
            end else begin
                want = verdict_q.pop_front();
                if (o_data.matched !== want.matched) begin
                    $display("%0t: matched expected %0b got %0b",
                             $time, want.matched, o_data.matched);
                    err_cnt++;
                end
                if (o_data.pattern_overflow !== want.pattern_overflow) begin
                    $display("%0t: pattern_overflow expected %0b got %0b",
                             $time, want.pattern_overflow, o_data.pattern_overflow);
                    err_cnt++;
                end
            end
        end
    end

    // no item moving on either channel for too long means a hang
    int unsigned idle_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_front.sv
hw/rtl/wgm_queue.sv
hw/rtl/wgm_back.sv
hw/rtl/wildcard_glob_matcher.sv
hw/rtl/wgm_checker.sv
verif/tb_top.sv
